@@ rtl/ialu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_pkg: shared types and codes for the pipelined integer ALU
// Opcodes, error codes and the payload structs of both channels.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FIELD_W        = 32;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_LSR = 4'd4;
  localparam logic [3:0] OP_ASR = 4'd5;
  localparam logic [3:0] OP_LSL = 4'd6;
  localparam logic [3:0] OP_AND = 4'd7;
  localparam logic [3:0] OP_OR  = 4'd8;
  localparam logic [3:0] OP_XOR = 4'd9;
  localparam logic [3:0] OP_NEG = 4'd10;
  localparam logic [3:0] OP_NOT = 4'd11;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
  localparam logic [1:0] ERR_BAD_OP   = 2'd2;

  typedef struct packed {
    logic [3:0]         op;
    logic [FIELD_W-1:0] operand_a;
    logic [FIELD_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result;
    logic [1:0]         error;
  } out_t;

endpackage
`default_nettype wire

@@ rtl/ialu_div_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_div_step: one restoring division step
// Shifts one dividend bit into the partial remainder and produces one
// quotient bit.
// ----------------------------------------------------------------------------
module ialu_div_step import ialu_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] quo_i,
  input  logic [W-1:0] dv_i,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] quo_o
);

  logic [W:0] trial;
  logic [W:0] diff;

  assign trial = {rem_i, quo_i[W-1]};
  assign diff  = trial - {1'b0, dv_i};

  // borrow out means the divisor did not fit: restore
  assign rem_o = diff[W] ? trial[W-1:0] : diff[W-1:0];
  assign quo_o = {quo_i[W-2:0], ~diff[W]};

endmodule
`default_nettype wire

@@ rtl/integer_alu_32.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// integer_alu_32: pipelined integer ALU
// Add, sub, mul (low word), unsigned div, shifts, logic ops, neg and not.
// ----------------------------------------------------------------------------
// A new beat is taken every cycle while in_ready is high. The pipeline depth
// comes from the divider, which resolves one quotient bit per pipeline stage;
// all other operations ride along in the same stages. The multiplier is split
// into half-width partial products in the entry stage and summed in the next.
// Empty stages close up under output stall, so input beats keep flowing until
// the whole pipeline is full. Operands are taken modulo 2^DATA_WIDTH; shifts by
// DATA_WIDTH or more give zero (sign fill for asr); divide by zero and unknown
// opcodes return result 0 with an error code.
// ----------------------------------------------------------------------------
module integer_alu_32 import ialu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int W   = DATA_WIDTH;
  localparam int H   = (W + 1) / 2;
  localparam int L   = W - H;
  localparam int NS  = W + 2;
  localparam int SHW = $clog2(W);

  typedef struct packed {
    logic [3:0]   op;
    logic [1:0]   err;
    logic [W-1:0] res;
    logic [W-1:0] pp0;
    logic [L-1:0] pp1;
    logic [L-1:0] pp2;
    logic [W-1:0] dv;
    logic [W-1:0] quo;
  } entry_t;

  typedef struct packed {
    logic [3:0]   op;
    logic [1:0]   err;
    logic [W-1:0] res;
    logic [W-1:0] dv;
    logic [W-1:0] rem;
    logic [W-1:0] quo;
  } step_t;

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  // a stage may load when the output is ready or any stage from it to the output is empty
  for (genvar i = 0; i < NS; i++) begin : g_rdy
    assign rdy[i] = out_ready | ~(&v_r[NS-1:i]);
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

  // entry stage
  logic [W-1:0]   a_w, b_w, asr_v;
  logic [SHW-1:0] sh;
  logic           big;
  logic [2*H-1:0] p0;
  logic [W-1:0]   p1, p2;
  entry_t         e_nxt, e_r;

  assign a_w   = W'(in_data.operand_a);
  assign b_w   = W'(in_data.operand_b);
  assign sh    = b_w[SHW-1:0];
  assign big   = (b_w >= W'(W));
  assign asr_v = $signed(a_w) >>> sh;
  assign p0    = a_w[H-1:0] * b_w[H-1:0];
  assign p1    = a_w[W-1:H] * b_w[H-1:0];
  assign p2    = a_w[H-1:0] * b_w[W-1:H];

  always_comb begin
    e_nxt.op  = in_data.op;
    e_nxt.err = ERR_NONE;
    e_nxt.res = '0;
    e_nxt.pp0 = p0[W-1:0];
    e_nxt.pp1 = p1[L-1:0];
    e_nxt.pp2 = p2[L-1:0];
    e_nxt.dv  = b_w;
    e_nxt.quo = a_w;
    case (in_data.op)
      OP_ADD: e_nxt.res = a_w + b_w;
      OP_SUB: e_nxt.res = a_w - b_w;
      OP_MUL: e_nxt.res = '0;
      OP_DIV: begin
        if (b_w == '0) e_nxt.err = ERR_DIV_ZERO;
      end
      OP_LSR: e_nxt.res = big ? '0 : (a_w >> sh);
      OP_ASR: e_nxt.res = big ? {W{a_w[W-1]}} : asr_v;
      OP_LSL: e_nxt.res = big ? '0 : (a_w << sh);
      OP_AND: e_nxt.res = a_w & b_w;
      OP_OR:  e_nxt.res = a_w | b_w;
      OP_XOR: e_nxt.res = a_w ^ b_w;
      OP_NEG: e_nxt.res = '0 - a_w;
      OP_NOT: e_nxt.res = ~a_w;
      default: e_nxt.err = ERR_BAD_OP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      e_r <= e_nxt;
    end
  end

  // divider stages, one quotient bit each; stage 1 also folds the product
  step_t        s_in  [1:W];
  step_t        s_nxt [1:W];
  step_t        s_r   [1:W];
  logic [W-1:0] mul_sum;

  assign mul_sum = e_r.pp0 + {L'(e_r.pp1 + e_r.pp2), {H{1'b0}}};

  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [W-1:0] rem_o, quo_o;

    if (k == 1) begin : g_first
      always_comb begin
        s_in[k].op  = e_r.op;
        s_in[k].err = e_r.err;
        s_in[k].res = (e_r.op == OP_MUL) ? mul_sum : e_r.res;
        s_in[k].dv  = e_r.dv;
        s_in[k].rem = '0;
        s_in[k].quo = e_r.quo;
      end
    end else begin : g_rest
      assign s_in[k] = s_r[k-1];
    end

    ialu_div_step #(.W(W)) u_step (
      .rem_i (s_in[k].rem),
      .quo_i (s_in[k].quo),
      .dv_i  (s_in[k].dv),
      .rem_o (rem_o),
      .quo_o (quo_o)
    );

    always_comb begin
      s_nxt[k]     = s_in[k];
      s_nxt[k].rem = rem_o;
      s_nxt[k].quo = quo_o;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_r[k-1]) begin
        s_r[k] <= s_nxt[k];
      end
    end
  end

  // output register
  out_t         out_nxt, out_r;
  logic [W-1:0] sel;

  assign sel = (s_r[W].op == OP_DIV) ? s_r[W].quo : s_r[W].res;

  always_comb begin
    out_nxt.error  = s_r[W].err;
    out_nxt.result = (s_r[W].err != ERR_NONE) ? '0 : FIELD_W'(sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[NS-1] <= 1'b0;
    end else if (rdy[NS-1]) begin
      v_r[NS-1] <= v_r[NS-2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1] && v_r[NS-2]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.error != ERR_NONE) |-> out_data.result == '0)
    else $error("error beat with nonzero result");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.error == ERR_NONE) || (out_data.error == ERR_DIV_ZERO) ||
                  (out_data.error == ERR_BAD_OP))
    else $error("undefined error code");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready && (&v_r))
    else $error("input blocked while pipeline has room");

endmodule
`default_nettype wire
